/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CSVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvs: check failed");

// next-cycle implication, disabled in reset
`define CSVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvs: check failed");

`endif

/* rtl/csvs_pkg.sv */
`default_nettype none
package csvs_pkg;

  localparam logic [7:0] QUOTE_CHAR     = 8'h22;
  localparam logic [7:0] COMMA_CHAR     = 8'h2C;
  localparam logic [4:0] MAX_FIELDS_RST = 5'd11;
  localparam logic [4:0] FIELD_CAP      = 5'd16;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_out;
    logic [3:0] field_index;
    logic       has_char;
    logic       field_end;
    logic       line_end;
    logic       quote_error;
  } res_t;

  // one or two results caused by one input item
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic       between;
    logic [4:0] cnt;
  } fst_t;

endpackage
`default_nettype wire

/* rtl/quoted_csv_field_splitter.sv */
// channel | dir | handshake           | payload
// in      | in  | in_valid / in_stall | in_data_byte, in_end_of_line
// out     | out | out_valid/out_stall | out_char_out .. out_is_last
// cfg     | in  | cfg_wr_en           | cfg_wr_data (max_fields)
//
// One byte per cycle is accepted while in_stall is low; the mode/counter update is
// registered in the front. Results leave one per cycle from the output register
// while out_stall is low; an item with two results holds the back end until both have
// left, absorbed by a 4-entry queue that sits before the output register.
// Reset (rst_n, synchronous): between fields, count 0, max_fields 11, queue empty.
// in_stall is high only while the queue is full.
`default_nettype none
`include "assert_macros.svh"
module quoted_csv_field_splitter
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_line,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic [3:0]      out_field_index,
  output logic            out_has_char,
  output logic            out_field_end,
  output logic            out_line_end,
  output logic            out_quote_error,
  output logic            out_is_last
);

  logic            acc;
  logic            push, pop, nempty, full;
  entry_t          push_data, head;
  fst_t            fst;
  res_t            res;
  logic [Q_CW-1:0] q_count;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  csvs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .data_byte   (in_data_byte),
    .end_of_line (in_end_of_line),
    .push        (push),
    .push_data   (push_data),
    .st          (fst)
  );

  csvs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nempty    (nempty),
    .full      (full),
    .count     (q_count)
  );

  csvs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .nempty      (nempty),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (res),
    .out_is_last (out_is_last)
  );

  assign out_char_out    = res.char_out;
  assign out_field_index = res.field_index;
  assign out_has_char    = res.has_char;
  assign out_field_end   = res.field_end;
  assign out_line_end    = res.line_end;
  assign out_quote_error = res.quote_error;

  `CSVS_ASSERT_NXT(a_eol_clears, clk, rst_n, acc && in_end_of_line, fst.between && (fst.cnt == 5'd0))
  `CSVS_ASSERT_NXT(a_eol_result, clk, rst_n, acc && in_end_of_line, (q_count != '0) || out_valid)
  `CSVS_ASSERT_NXT(a_q_grow, clk, rst_n, push && !pop, q_count == $past(q_count) + Q_CW'(1))
  `CSVS_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, fst.cnt <= FIELD_CAP)

endmodule
`default_nettype wire

/* rtl/csvs_front.sv */
`default_nettype none
module csvs_front
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  input  wire logic       acc,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_line,
  output logic            push,
  output entry_t          push_data,
  output fst_t            st
);

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] max_fields_r;
  logic [4:0] lim;
  logic [4:0] cnt_p1;
  logic       is_q, is_c, can_start, can_start2;
  logic [1:0] nres;
  res_t       r0, r1;

  always_comb begin
    is_q       = (data_byte == QUOTE_CHAR);
    is_c       = (data_byte == COMMA_CHAR);
    lim        = (max_fields_r > FIELD_CAP) ? FIELD_CAP : max_fields_r;
    cnt_p1     = cnt_r + 5'd1;
    can_start  = (cnt_r < lim);
    can_start2 = (cnt_p1 < lim);
    nres       = 2'd0;
    r0         = '0;
    r1         = '0;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    if (end_of_line) begin
      nres        = 2'd1;
      r0.line_end = 1'b1;
      mode_nxt    = MODE_BETWEEN;
      cnt_nxt     = 5'd0;
      if (mode_r != MODE_BETWEEN) begin
        r0.field_index = cnt_r[3:0];
        r0.field_end   = 1'b1;
        r0.quote_error = (mode_r == MODE_QUOTED);
      end
    end else begin
      unique case (mode_r)
        MODE_BETWEEN: begin
          if (can_start) begin
            if (is_q) begin
              mode_nxt = MODE_QUOTED;
            end else if (is_c) begin
              nres           = 2'd1;
              r0.field_index = cnt_r[3:0];
              r0.field_end   = 1'b1;
              cnt_nxt        = cnt_p1;
            end else begin
              nres           = 2'd1;
              r0.char_out    = data_byte;
              r0.field_index = cnt_r[3:0];
              r0.has_char    = 1'b1;
              mode_nxt       = MODE_PLAIN;
            end
          end
        end
        MODE_PLAIN: begin
          nres           = 2'd1;
          r0.field_index = cnt_r[3:0];
          if (is_c) begin
            r0.field_end = 1'b1;
            cnt_nxt      = cnt_p1;
            mode_nxt     = MODE_BETWEEN;
          end else begin
            r0.char_out = data_byte;
            r0.has_char = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (is_q) begin
            mode_nxt = MODE_QSEEN;
          end else begin
            nres           = 2'd1;
            r0.char_out    = data_byte;
            r0.field_index = cnt_r[3:0];
            r0.has_char    = 1'b1;
          end
        end
        MODE_QSEEN: begin
          if (is_q) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            nres           = 2'd1;
            r0.field_index = cnt_r[3:0];
            r0.field_end   = 1'b1;
            cnt_nxt        = cnt_p1;
            mode_nxt       = MODE_BETWEEN;
            // a non-comma byte after the closing quote also starts the next field, if the limit allows
            if (!is_c && can_start2) begin
              nres           = 2'd2;
              r1.char_out    = data_byte;
              r1.field_index = cnt_p1[3:0];
              r1.has_char    = 1'b1;
              mode_nxt       = MODE_PLAIN;
            end
          end
        end
        default: mode_nxt = MODE_BETWEEN;
      endcase
    end
  end

  assign push          = acc && (nres != 2'd0);
  assign push_data.r0  = r0;
  assign push_data.r1  = r1;
  assign push_data.two = (nres == 2'd2);
  assign st.between    = (mode_r == MODE_BETWEEN);
  assign st.cnt        = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BETWEEN;
      cnt_r        <= 5'd0;
      max_fields_r <= MAX_FIELDS_RST;
    end else begin
      if (cfg_wr_en) begin
        max_fields_r <= cfg_wr_data;
      end
      if (acc) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/csvs_fifo.sv */
`default_nettype none
module csvs_fifo
  import csvs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire entry_t          push_data,
  input  wire logic            pop,
  output entry_t               head,
  output logic                 nempty,
  output logic                 full,
  output logic [Q_CW-1:0]      count
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign head   = mem_r[rd_ptr_r];
  assign nempty = (cnt_r != '0);
  assign full   = (cnt_r == Q_CW'(Q_DEPTH));
  assign count  = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/csvs_back.sv */
`default_nettype none
module csvs_back
  import csvs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire entry_t head,
  input  wire logic   nempty,
  output logic        pop,
  input  wire logic   out_stall,
  output logic        out_valid,
  output res_t        out_res,
  output logic        out_is_last
);

  logic out_valid_r;
  logic sel_r;
  res_t res_r;
  logic is_last_r;
  logic load, last;

  assign load = !out_valid_r || !out_stall;
  assign last = !head.two || sel_r;
  assign pop  = load && nempty && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= nempty;
      if (nempty) begin
        sel_r <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && nempty) begin
      res_r     <= sel_r ? head.r1 : head.r0;
      is_last_r <= last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res     = res_r;
  assign out_is_last = is_last_r;

endmodule
`default_nettype wire

/* verif/csv_split_checker.sv */
`timescale 1ns / 100ps
module csv_split_checker
  import csvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_line,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char_out,
  input  logic [3:0] out_field_index,
  input  logic       out_has_char,
  input  logic       out_field_end,
  input  logic       out_line_end,
  input  logic       out_quote_error,
  input  logic       out_is_last,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN
  } split_mode_e;

  typedef struct packed {
    logic [7:0] char_out;
    logic [3:0] field_index;
    logic       has_char;
    logic       field_end;
    logic       line_end;
    logic       quote_error;
    logic       is_last;
  } split_res_t;

  split_res_t  expected_q[$];
  split_res_t  step_q[$];
  split_mode_e mode;
  logic [4:0]  fields_done;
  logic [4:0]  max_fields;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void emit(input logic [7:0] ch, input logic [3:0] idx, input logic has,
                               input logic fe, input logic le, input logic qe);
    split_res_t r;
    r.char_out    = ch;
    r.field_index = idx;
    r.has_char    = has;
    r.field_end   = fe;
    r.line_end    = le;
    r.quote_error = qe;
    r.is_last     = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void close_field();
    emit(8'h00, fields_done[3:0], 1'b0, 1'b1, 1'b0, 1'b0);
    fields_done = fields_done + 5'd1;
    mode = MODE_BETWEEN;
  endfunction

  function automatic void start_field(input logic [7:0] b);
    logic [4:0] lim;
    lim = (max_fields > FIELD_CAP) ? FIELD_CAP : max_fields;
    if (fields_done >= lim) return;
    if (b == QUOTE_CHAR) begin
      mode = MODE_QUOTED;
    end else if (b == COMMA_CHAR) begin
      close_field();
    end else begin
      emit(b, fields_done[3:0], 1'b1, 1'b0, 1'b0, 1'b0);
      mode = MODE_PLAIN;
    end
  endfunction

  function automatic void predict_split(input logic [7:0] b, input logic eol);
    step_q.delete();
    if (eol) begin
      case (mode)
        MODE_PLAIN, MODE_QSEEN: begin
          emit(8'h00, fields_done[3:0], 1'b0, 1'b1, 1'b1, 1'b0);
        end
        MODE_QUOTED: begin
          emit(8'h00, fields_done[3:0], 1'b0, 1'b1, 1'b1, 1'b1);
        end
        default: begin
          emit(8'h00, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0);
        end
      endcase
      mode = MODE_BETWEEN;
      fields_done = 5'd0;
    end else begin
      case (mode)
        MODE_BETWEEN: begin
          start_field(b);
        end
        MODE_PLAIN: begin
          if (b == COMMA_CHAR) close_field();
          else emit(b, fields_done[3:0], 1'b1, 1'b0, 1'b0, 1'b0);
        end
        MODE_QUOTED: begin
          if (b == QUOTE_CHAR) mode = MODE_QSEEN;
          else emit(b, fields_done[3:0], 1'b1, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          if (b == QUOTE_CHAR) begin
            mode = MODE_QUOTED;
          end else if (b == COMMA_CHAR) begin
            close_field();
          end else begin
            close_field();
            start_field(b);
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].is_last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    split_res_t want;
    if (!rst_n) begin
      mode        = MODE_BETWEEN;
      fields_done = 5'd0;
      max_fields  = MAX_FIELDS_RST;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) max_fields = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected, field_index %0d", out_field_index);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("char_out", 32'(want.char_out), 32'(out_char_out));
          check_field("field_index", 32'(want.field_index), 32'(out_field_index));
          check_field("has_char", 32'(want.has_char), 32'(out_has_char));
          check_field("field_end", 32'(want.field_end), 32'(out_field_end));
          check_field("line_end", 32'(want.line_end), 32'(out_line_end));
          check_field("quote_error", 32'(want.quote_error), 32'(out_quote_error));
          check_field("is_last", 32'(want.is_last), 32'(out_is_last));
        end
      end
      if (in_valid && !in_stall) predict_split(in_data_byte, in_end_of_line);
    end
    pending = expected_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb;
  import csvs_pkg::*;

  localparam logic [8:0] DQ  = {1'b0, QUOTE_CHAR};
  localparam logic [8:0] CM  = {1'b0, COMMA_CHAR};
  localparam logic [8:0] EOL = 9'h100;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       cfg_wr_en      = 1'b0;
  logic [4:0] cfg_wr_data    = 5'd0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte   = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_char_out;
  logic [3:0] out_field_index;
  logic       out_has_char;
  logic       out_field_end;
  logic       out_line_end;
  logic       out_quote_error;
  logic       out_is_last;
  int         fail_count;
  int         pending;

  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int bytes_sent    = 0;

  // zero byte, quoted comma, doubled quote, quote then byte, trailing comma,
  // empty line, unterminated quote, line end after closing quote, plain end
  logic [8:0] directed_seq [25] = '{
    9'h000, CM, DQ, CM, DQ, DQ, 9'h071, DQ, CM, DQ, 9'h07A, DQ, 9'h0FF, CM, EOL,
    EOL, DQ, 9'h061, EOL, DQ, 9'h062, DQ, EOL, 9'h078, EOL
  };

  logic [4:0] phase_limit [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd11, 5'd0};

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  quoted_csv_field_splitter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_field_index (out_field_index),
    .out_has_char    (out_has_char),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_quote_error (out_quote_error),
    .out_is_last     (out_is_last)
  );

  csv_split_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_end_of_line  (in_end_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_field_index (out_field_index),
    .out_has_char    (out_has_char),
    .out_field_end   (out_field_end),
    .out_line_end    (out_line_end),
    .out_quote_error (out_quote_error),
    .out_is_last     (out_is_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic push_byte(input logic [7:0] b, input logic eol);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic gen_line();
    int nf;
    int kind;
    int len;
    logic [7:0] b;
    nf = $urandom_range(0, 18);
    for (int f = 0; f < nf; f++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(0, 255));
          while (b == COMMA_CHAR || (i == 0 && b == QUOTE_CHAR));
          push_byte(b, 1'b0);
        end
        if (f < nf - 1) push_byte(COMMA_CHAR, 1'b0);
      end else if (kind < 8) begin
        push_byte(QUOTE_CHAR, 1'b0);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              push_byte(QUOTE_CHAR, 1'b0);
              push_byte(QUOTE_CHAR, 1'b0);
            end
            1: push_byte(COMMA_CHAR, 1'b0);
            default: begin
              do b = 8'($urandom_range(0, 255)); while (b == QUOTE_CHAR);
              push_byte(b, 1'b0);
            end
          endcase
        end
        push_byte(QUOTE_CHAR, 1'b0);
        if (f < nf - 1 && $urandom_range(0, 3) != 0) push_byte(COMMA_CHAR, 1'b0);
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 2))
            0: push_byte(QUOTE_CHAR, 1'b0);
            1: push_byte(COMMA_CHAR, 1'b0);
            default: push_byte(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
      end else begin
        push_byte(QUOTE_CHAR, 1'b0);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(0, 255)); while (b == QUOTE_CHAR);
          push_byte(b, 1'b0);
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
    end
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int goal;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_seq[i]) push_byte(directed_seq[i][7:0], directed_seq[i][8]);
    drain(4);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 60; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 60; end
        default: begin in_gap_pct = 15; out_stall_pct = 15; end
      endcase
      write_limit((ph == 7) ? 5'($urandom_range(0, 31)) : phase_limit[ph]);
      goal = bytes_sent + 175;
      while (bytes_sent < goal) gen_line();
      drain(4);
    end

    out_stall_pct = 0;
    drain(8);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
